/* hw/rtl/etl_pkg.sv */
// ----------------------------------------------------------------------------
// etl_pkg: expression token lexer definitions
// Lexer modes, token kinds, diagnostic codes, record type and character
// classes shared by the lexer RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

  localparam int unsigned PositionWidthDefault = 16;
  localparam int unsigned RecMax               = 6;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [4:0] {
    M_IDLE, M_DOT, M_IDENT, M_STRING, M_LT, M_GT, M_EQ, M_BANG, M_AMP,
    M_BAR, M_ZERO, M_INT, M_FRAC, M_HX, M_HXDOT, M_HINT, M_HFRAC,
    M_EMARK, M_ESIGN, M_EDIG
  } mode_t;

  typedef enum logic [4:0] {
    K_NUM = 5'd0, K_TEXT = 5'd1, K_NAME = 5'd2, K_PLUS = 5'd3, K_MINUS = 5'd4,
    K_STAR = 5'd5, K_SLASH = 5'd6, K_PCT = 5'd7, K_CARET = 5'd8, K_BANG = 5'd9,
    K_LT = 5'd10, K_LE = 5'd11, K_GT = 5'd12, K_GE = 5'd13, K_EQEQ = 5'd14,
    K_NE = 5'd15, K_ANDAND = 5'd16, K_OROR = 5'd17, K_LP = 5'd18, K_RP = 5'd19,
    K_COMMA = 5'd20, K_END = 5'd21, K_INVALID = 5'd22
  } kind_t;

  typedef enum logic [1:0] {
    D_UNTERMINATED = 2'd0,
    D_LONE_EQUALS  = 2'd1,
    D_UNEXPECTED   = 2'd2
  } diag_t;

  typedef struct packed {
    logic        is_diag;
    kind_t       kind;
    diag_t       code;
    logic [15:0] start;
    logic [15:0] len;
  } rec_t;

  typedef struct packed {
    rec_t [RecMax-1:0] r;
    logic [2:0]        n;
  } rlist_t;

  function automatic rec_t mk_tok(kind_t k, logic [15:0] s, logic [15:0] l);
    rec_t r;
    r.is_diag = 1'b0;
    r.kind    = k;
    r.code    = D_UNTERMINATED;
    r.start   = s;
    r.len     = l;
    return r;
  endfunction

  function automatic rec_t mk_diag(diag_t d, logic [15:0] s, logic [15:0] l);
    rec_t r;
    r.is_diag = 1'b1;
    r.kind    = K_INVALID;
    r.code    = d;
    r.start   = s;
    r.len     = l;
    return r;
  endfunction

  function automatic rlist_t add(rlist_t l, logic v, rec_t r);
    rlist_t o;
    o = l;
    if (v && (l.n < 3'(RecMax))) begin
      o.r[l.n] = r;
      o.n      = l.n + 3'd1;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/expression_token_lexer.sv */
// ----------------------------------------------------------------------------
// expression_token_lexer: streaming expression tokenizer
// Turns a character stream into token and diagnostic records with spans.
// ----------------------------------------------------------------------------
// One character or end marker enters per cycle while in_ready is high. Each
// item is lexed in the same cycle it is accepted, including replay of up to
// two lookahead characters after a failed number tail, and its records (zero
// to six) land in a six-entry result buffer. Records leave one per cycle
// while out_ready is high; a new item is taken once the buffer is empty or
// its last record transfers. Positions saturate at 2^POSITION_WIDTH-1.
`default_nettype none

module expression_token_lexer
  import etl_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_diagnostic,
  output logic [4:0]       token_kind,
  output logic [1:0]       diag_code,
  output logic [15:0]      span_start,
  output logic [15:0]      span_length,
  output logic             last_of_run
);

  localparam int unsigned P = POSITION_WIDTH;

  typedef struct packed {
    mode_t          mode;
    logic [P-1:0]   tb;
    logic [7:0]     la0;
    logic [7:0]     la1;
    logic [1:0]     lacnt;
    logic [P-1:0]   mark;
  } lex_t;

  typedef struct packed {
    lex_t st;
    logic v0;
    rec_t r0;
    logic v1;
    rec_t r1;
  } step_t;

  function automatic logic [P-1:0] sat1(logic [P-1:0] p);
    return (p == {P{1'b1}}) ? p : p + {{(P-1){1'b0}}, 1'b1};
  endfunction

  function automatic step_t feed1(lex_t s, logic [7:0] c, logic [P-1:0] pos);
    step_t       o;
    logic        go_idle;
    logic        rv;
    rec_t        r;
    logic [7:0]  second;
    logic [15:0] blen;
    logic [15:0] tb16;
    o       = '0;
    o.st    = s;
    go_idle = 1'b0;
    rv      = 1'b0;
    r       = '0;
    second  = CH_EQUALS;
    blen    = 16'(pos - s.tb);
    tb16    = 16'(s.tb);
    case (s.mode)
      M_IDLE: go_idle = 1'b1;
      M_DOT: begin
        if (is_digit(c)) begin
          o.st.mode = M_FRAC;
        end else begin
          o.v0 = 1'b1; o.r0 = mk_diag(D_UNEXPECTED, tb16, 16'd1); go_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (!(is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE || c == CH_DOT)) begin
          o.v0 = 1'b1; o.r0 = mk_tok(K_NAME, tb16, blen); go_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          o.v0 = 1'b1;
          o.r0 = mk_tok(K_TEXT, tb16, 16'(sat1(pos) - s.tb));
          o.st.mode = M_IDLE;
        end
      end
      M_LT, M_GT, M_BANG, M_EQ, M_AMP, M_BAR: begin
        if (s.mode == M_AMP) second = "&";
        else if (s.mode == M_BAR) second = "|";
        o.v0 = 1'b1;
        if (c == second) begin
          o.st.mode = M_IDLE;
          unique case (s.mode)
            M_LT:    o.r0 = mk_tok(K_LE, tb16, 16'd2);
            M_GT:    o.r0 = mk_tok(K_GE, tb16, 16'd2);
            M_BANG:  o.r0 = mk_tok(K_NE, tb16, 16'd2);
            M_EQ:    o.r0 = mk_tok(K_EQEQ, tb16, 16'd2);
            M_AMP:   o.r0 = mk_tok(K_ANDAND, tb16, 16'd2);
            default: o.r0 = mk_tok(K_OROR, tb16, 16'd2);
          endcase
        end else begin
          go_idle = 1'b1;
          unique case (s.mode)
            M_LT:    o.r0 = mk_tok(K_LT, tb16, 16'd1);
            M_GT:    o.r0 = mk_tok(K_GT, tb16, 16'd1);
            M_BANG:  o.r0 = mk_tok(K_BANG, tb16, 16'd1);
            M_EQ:    o.r0 = mk_diag(D_LONE_EQUALS, tb16, 16'd1);
            default: o.r0 = mk_diag(D_UNEXPECTED, tb16, 16'd1);
          endcase
        end
      end
      M_ZERO, M_INT, M_FRAC: begin
        if (s.mode == M_ZERO && (c == "x" || c == "X")) begin
          o.st.la0 = c; o.st.lacnt = 2'd1; o.st.mark = pos; o.st.mode = M_HX;
        end else if (is_digit(c)) begin
          if (s.mode != M_FRAC) o.st.mode = M_INT;
        end else if (s.mode != M_FRAC && c == CH_DOT) begin
          o.st.mode = M_FRAC;
        end else if (c == "e" || c == "E") begin
          o.st.la0 = c; o.st.lacnt = 2'd1; o.st.mark = pos; o.st.mode = M_EMARK;
        end else begin
          o.v0 = 1'b1; o.r0 = mk_tok(K_NUM, tb16, blen); go_idle = 1'b1;
        end
      end
      M_HX: begin
        if (is_hex(c)) begin
          o.st.lacnt = 2'd0; o.st.mode = M_HINT;
        end else if (c == CH_DOT) begin
          o.st.la1 = c; o.st.lacnt = 2'd2; o.st.mode = M_HXDOT;
        end
      end
      M_HXDOT: begin
        if (is_hex(c)) begin
          o.st.lacnt = 2'd0; o.st.mode = M_HFRAC;
        end
      end
      M_HINT, M_HFRAC: begin
        if (s.mode == M_HINT && c == CH_DOT) begin
          o.st.mode = M_HFRAC;
        end else if (is_hex(c)) begin
          o.st.mode = s.mode;
        end else if (c == "p" || c == "P") begin
          o.st.la0 = c; o.st.lacnt = 2'd1; o.st.mark = pos; o.st.mode = M_EMARK;
        end else begin
          o.v0 = 1'b1; o.r0 = mk_tok(K_NUM, tb16, blen); go_idle = 1'b1;
        end
      end
      M_EMARK, M_ESIGN: begin
        if (s.mode == M_EMARK && (c == "+" || c == "-")) begin
          o.st.la1 = c; o.st.lacnt = 2'd2; o.st.mode = M_ESIGN;
        end else if (is_digit(c)) begin
          o.st.lacnt = 2'd0; o.st.mode = M_EDIG;
        end
      end
      M_EDIG: begin
        if (!is_digit(c)) begin
          o.v0 = 1'b1; o.r0 = mk_tok(K_NUM, tb16, blen); go_idle = 1'b1;
        end
      end
      default: go_idle = 1'b1;
    endcase
    if (go_idle) begin
      o.st.mode = M_IDLE;
      o.st.tb   = pos;
      if (is_space(c)) begin
        o.st.mode = M_IDLE;
      end else if (is_digit(c)) begin
        o.st.mode = (c == "0") ? M_ZERO : M_INT;
      end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
        o.st.mode = M_IDENT;
      end else begin
        case (c)
          CH_DOT:    o.st.mode = M_DOT;
          CH_QUOTE:  o.st.mode = M_STRING;
          "<":       o.st.mode = M_LT;
          ">":       o.st.mode = M_GT;
          CH_EQUALS: o.st.mode = M_EQ;
          "!":       o.st.mode = M_BANG;
          "&":       o.st.mode = M_AMP;
          "|":       o.st.mode = M_BAR;
          "+": begin rv = 1'b1; r = mk_tok(K_PLUS, 16'(pos), 16'd1); end
          "-": begin rv = 1'b1; r = mk_tok(K_MINUS, 16'(pos), 16'd1); end
          "*": begin rv = 1'b1; r = mk_tok(K_STAR, 16'(pos), 16'd1); end
          "/": begin rv = 1'b1; r = mk_tok(K_SLASH, 16'(pos), 16'd1); end
          "%": begin rv = 1'b1; r = mk_tok(K_PCT, 16'(pos), 16'd1); end
          "^": begin rv = 1'b1; r = mk_tok(K_CARET, 16'(pos), 16'd1); end
          "(": begin rv = 1'b1; r = mk_tok(K_LP, 16'(pos), 16'd1); end
          ")": begin rv = 1'b1; r = mk_tok(K_RP, 16'(pos), 16'd1); end
          ",": begin rv = 1'b1; r = mk_tok(K_COMMA, 16'(pos), 16'd1); end
          default: begin rv = 1'b1; r = mk_diag(D_UNEXPECTED, 16'(pos), 16'd1); end
        endcase
      end
      if (o.v0) begin
        o.v1 = rv; o.r1 = r;
      end else begin
        o.v0 = rv; o.r0 = r;
      end
    end
    return o;
  endfunction

  function automatic step_t flush1(lex_t s, logic [P-1:0] cp);
    step_t       o;
    logic [15:0] tb16;
    logic [15:0] blen;
    o    = '0;
    o.st = s;
    tb16 = 16'(s.tb);
    blen = 16'(cp - s.tb);
    o.v0 = 1'b1;
    case (s.mode)
      M_IDLE:   o.v0 = 1'b0;
      M_DOT:    o.r0 = mk_diag(D_UNEXPECTED, tb16, 16'd1);
      M_IDENT:  o.r0 = mk_tok(K_NAME, tb16, blen);
      M_STRING: begin
        o.r0 = mk_diag(D_UNTERMINATED, tb16, blen);
        o.v1 = 1'b1;
        o.r1 = mk_tok(K_TEXT, tb16, blen);
      end
      M_LT:     o.r0 = mk_tok(K_LT, tb16, 16'd1);
      M_GT:     o.r0 = mk_tok(K_GT, tb16, 16'd1);
      M_BANG:   o.r0 = mk_tok(K_BANG, tb16, 16'd1);
      M_EQ:     o.r0 = mk_diag(D_LONE_EQUALS, tb16, 16'd1);
      M_AMP, M_BAR: o.r0 = mk_diag(D_UNEXPECTED, tb16, 16'd1);
      M_ZERO, M_INT, M_FRAC, M_HINT, M_HFRAC, M_EDIG:
                o.r0 = mk_tok(K_NUM, tb16, blen);
      default:  o.v0 = 1'b0;
    endcase
    return o;
  endfunction

  lex_t         st;
  lex_t         st_next;
  logic [P-1:0] cp;
  logic [P-1:0] cp_next;
  rlist_t       recs;
  rlist_t       obuf;
  logic [2:0]   ocnt;
  logic [2:0]   ord;
  logic         in_xfer;
  logic         out_xfer;
  logic         last_rec;

  always_comb begin
    lex_t  s;
    step_t f;
    logic  bt;
    s    = st;
    recs = '0;
    f    = '0;
    unique case (st.mode)
      M_HX:    bt = (op == OP_END) || (!is_hex(char_code) && char_code != CH_DOT);
      M_HXDOT: bt = (op == OP_END) || !is_hex(char_code);
      M_EMARK: bt = (op == OP_END) ||
                    (!is_digit(char_code) && char_code != "+" && char_code != "-");
      M_ESIGN: bt = (op == OP_END) || !is_digit(char_code);
      default: bt = 1'b0;
    endcase
    if (bt) begin
      recs = add(recs, 1'b1, mk_tok(K_NUM, 16'(st.tb), 16'(st.mark - st.tb)));
      s.mode  = M_IDLE;
      s.lacnt = 2'd0;
      f = feed1(s, st.la0, st.mark);
      recs = add(recs, f.v0, f.r0);
      recs = add(recs, f.v1, f.r1);
      s = f.st;
      if (st.lacnt == 2'd2) begin
        f = feed1(s, st.la1, sat1(st.mark));
        recs = add(recs, f.v0, f.r0);
        recs = add(recs, f.v1, f.r1);
        s = f.st;
      end
    end
    if (op == OP_CHAR) begin
      f = feed1(s, char_code, cp);
      recs = add(recs, f.v0, f.r0);
      recs = add(recs, f.v1, f.r1);
      st_next = f.st;
      cp_next = sat1(cp);
    end else begin
      f = flush1(s, cp);
      recs = add(recs, f.v0, f.r0);
      recs = add(recs, f.v1, f.r1);
      recs = add(recs, 1'b1, mk_tok(K_END, 16'(cp), 16'd0));
      st_next       = s;
      st_next.mode  = M_IDLE;
      st_next.tb    = '0;
      st_next.lacnt = 2'd0;
      st_next.mark  = '0;
      cp_next       = '0;
    end
  end

  assign out_valid = (ocnt != 3'd0);
  assign last_rec  = (ord == 3'(ocnt - 3'd1));
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = !out_valid || (out_xfer && last_rec);
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode  <= M_IDLE;
      st.tb    <= '0;
      st.lacnt <= 2'd0;
      st.mark  <= '0;
      cp       <= '0;
    end else if (in_xfer) begin
      st <= st_next;
      cp <= cp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      obuf <= recs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 3'd0;
      ord  <= 3'd0;
    end else if (in_xfer) begin
      ocnt <= recs.n;
      ord  <= 3'd0;
    end else if (out_xfer) begin
      if (last_rec) begin
        ocnt <= 3'd0;
      end else begin
        ord <= ord + 3'd1;
      end
    end
  end

  assign is_diagnostic = obuf.r[ord].is_diag;
  assign token_kind    = obuf.r[ord].kind;
  assign diag_code     = obuf.r[ord].code;
  assign span_start    = obuf.r[ord].start;
  assign span_length   = obuf.r[ord].len;
  assign last_of_run   = last_rec;

endmodule

`default_nettype wire
